FILE: sv/fo_pkg.sv
// Shared types and constants for the factor oracle repeat builder.
// No dependencies; imported by the top level.
`default_nettype none

package fo_pkg;

    localparam int MAX_STATES_DEF  = 1024;
    localparam int MAX_EDGES_DEF   = 2048;
    localparam int SYMBOL_BITS_DEF = 8;

    // Fixed port widths
    localparam int IN_SYM_W = 8;
    localparam int OUT_W    = 10;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLR,
        ST_START,
        ST_LINK,
        ST_HEAD,
        ST_EDGE,
        ST_WEND,
        ST_CS0,
        ST_CS1,
        ST_CS2,
        ST_RF0,
        ST_RF1,
        ST_RF2,
        ST_FIN0,
        ST_FIN1,
        ST_OUT
    } fo_state_t;

endpackage

`default_nettype wire

FILE: sv/factor_oracle_repeat_builder.sv
// Top level of the factor oracle repeat builder: sequencer plus oracle stores.
// Depends on fo_pkg (types, constants) and fo_ram (store instances).
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-------------------------------------------
//   s_      | in  | s_valid / s_ready  | s_symbol[7:0], s_start_new
//   m_      | out | m_valid / m_ready  | m_state_index, m_suffix_link,
//           |     |                    | m_repeat_length, m_full_res
//
// One symbol at a time. Each symbol walks the suffix chain and probes the edge
// lists twice, a sizing pass and then a writing pass. A common-suffix walk
// (skipped when no transition was found or it leads to state zero) and a
// scan of the children of the link target follow; every step is one
// registered read of a store. A start_new transfer first passes through the
// clearing state, which after reset sets up state zero while s_ready stays low.
// A finished result waits in the output register; s_ready returns as soon as
// it is loaded, and the next result waits only if the previous is still held.
`default_nettype none

module factor_oracle_repeat_builder
    import fo_pkg::*;
#(
    parameter int MAX_STATES  = MAX_STATES_DEF,
    parameter int MAX_EDGES   = MAX_EDGES_DEF,
    parameter int SYMBOL_BITS = SYMBOL_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [IN_SYM_W-1:0] s_symbol,
    input  wire logic                s_start_new,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic      [OUT_W-1:0]    m_state_index,
    output logic      [OUT_W-1:0]    m_suffix_link,
    output logic      [OUT_W-1:0]    m_repeat_length,
    output logic                     m_full_res
);

    localparam int SW   = $clog2(MAX_STATES);
    localparam int EAW  = $clog2(MAX_EDGES);
    localparam int EPW  = $clog2(MAX_EDGES + 1);
    localparam int YB   = SYMBOL_BITS;
    localparam int NW   = SW + 1;
    localparam int SUMW = ((EPW > NW) ? EPW : NW) + 1;

    // ------------------------------------------------------------------
    // Registers
    fo_state_t st_reg, st_next;
    logic            pend_reg, pass2_reg, first_reg, found_reg;
    logic            a2ok_reg, cok_reg, res_full_reg;
    logic [YB-1:0]   a_reg, a2_reg;
    logic [SW-1:0]   cnt_reg, n_reg, i_reg, k_reg, src_reg, phi_reg, tgt_reg;
    logic [SW-1:0]   p2_reg, lp1_reg, rp1_reg, s_reg, l_reg, c_reg;
    logic [EPW-1:0]  ecnt_reg, head_reg;
    logic [NW-1:0]   need_reg;
    logic            m_valid_reg, m_full_reg;
    logic [OUT_W-1:0] m_idx_reg, m_link_reg, m_rep_reg;

    // ------------------------------------------------------------------
    // Store ports
    logic            hist_we, link_we, rep_we, fedge_we, chead_we, cnext_we, ctail_we;
    logic            edge_we;
    logic [SW-1:0]   hist_wa, link_wa, rep_wa, fedge_wa, chead_wa, cnext_wa, ctail_wa;
    logic [SW-1:0]   hist_ra, link_ra, rep_ra, fedge_ra, chead_ra, cnext_ra, ctail_ra;
    logic [EAW-1:0]  edge_wa, edge_ra;
    logic [YB-1:0]   hist_wd, esym_q, hist_q;
    logic [SW-1:0]   link_wd, rep_wd, chead_wd, cnext_wd, ctail_wd;
    logic [SW-1:0]   link_q, rep_q, chead_q, cnext_q, ctail_q, etgt_q;
    logic [EPW-1:0]  fedge_wd, enext_wd, fedge_q, enext_q;

    fo_ram #(.WIDTH(YB),  .DEPTH(MAX_STATES)) u_hist (
        .clk(aclk), .we(hist_we), .waddr(hist_wa), .wdata(hist_wd),
        .raddr(hist_ra), .rdata(hist_q));
    fo_ram #(.WIDTH(SW),  .DEPTH(MAX_STATES)) u_link (
        .clk(aclk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
        .raddr(link_ra), .rdata(link_q));
    fo_ram #(.WIDTH(SW),  .DEPTH(MAX_STATES)) u_rep (
        .clk(aclk), .we(rep_we), .waddr(rep_wa), .wdata(rep_wd),
        .raddr(rep_ra), .rdata(rep_q));
    fo_ram #(.WIDTH(EPW), .DEPTH(MAX_STATES)) u_fedge (
        .clk(aclk), .we(fedge_we), .waddr(fedge_wa), .wdata(fedge_wd),
        .raddr(fedge_ra), .rdata(fedge_q));
    fo_ram #(.WIDTH(SW),  .DEPTH(MAX_STATES)) u_chead (
        .clk(aclk), .we(chead_we), .waddr(chead_wa), .wdata(chead_wd),
        .raddr(chead_ra), .rdata(chead_q));
    fo_ram #(.WIDTH(SW),  .DEPTH(MAX_STATES)) u_cnext (
        .clk(aclk), .we(cnext_we), .waddr(cnext_wa), .wdata(cnext_wd),
        .raddr(cnext_ra), .rdata(cnext_q));
    fo_ram #(.WIDTH(SW),  .DEPTH(MAX_STATES)) u_ctail (
        .clk(aclk), .we(ctail_we), .waddr(ctail_wa), .wdata(ctail_wd),
        .raddr(ctail_ra), .rdata(ctail_q));
    fo_ram #(.WIDTH(YB),  .DEPTH(MAX_EDGES)) u_esym (
        .clk(aclk), .we(edge_we), .waddr(edge_wa), .wdata(a_reg),
        .raddr(edge_ra), .rdata(esym_q));
    fo_ram #(.WIDTH(SW),  .DEPTH(MAX_EDGES)) u_etgt (
        .clk(aclk), .we(edge_we), .waddr(edge_wa), .wdata(i_reg),
        .raddr(edge_ra), .rdata(etgt_q));
    fo_ram #(.WIDTH(EPW), .DEPTH(MAX_EDGES)) u_enext (
        .clk(aclk), .we(edge_we), .waddr(edge_wa), .wdata(enext_wd),
        .raddr(edge_ra), .rdata(enext_q));

    // ------------------------------------------------------------------
    // Shared decode
    logic           kok, edge_hit, head_miss, edge_miss, miss, full_now;
    logic           lp1ok, lp2ok, cs_eq, cs_cont, cs_short, rf_match, slot_free;
    logic [EPW-1:0] ecnt_inc, head_val, rd_ptr;
    logic [SW-1:0]  rep_min, rf_sym_src;
    logic [YB-1:0]  rf_sym;

    assign kok       = (src_reg != '0);
    assign edge_hit  = (esym_q == a_reg);
    assign head_miss = (fedge_q == '0);
    assign edge_miss = !edge_hit && (enext_q == '0);
    assign miss      = ((st_reg == ST_HEAD) && head_miss) ||
                       ((st_reg == ST_EDGE) && edge_miss);
    assign ecnt_inc  = ecnt_reg + EPW'(1);
    assign head_val  = (st_reg == ST_EDGE) ? head_reg : fedge_q;
    assign rd_ptr    = ((st_reg == ST_EDGE) ? enext_q : fedge_q) - EPW'(1);
    assign full_now  = (NW'(n_reg) + NW'(1) >= NW'(MAX_STATES)) ||
                       (SUMW'(ecnt_reg) + SUMW'(need_reg) > SUMW'(MAX_EDGES));

    // common-suffix walk; state zero is the only state without a link
    assign lp1ok    = (phi_reg != '0);
    assign lp2ok    = (p2_reg != '0);
    assign cs_short = lp1ok && (p2_reg == link_q);
    assign cs_eq    = (lp1ok == lp2ok) && (!lp1ok || (lp1_reg == link_q));
    assign cs_cont  = !cs_eq && lp2ok;
    assign rep_min  = (rp1_reg <= rep_q) ? rp1_reg : rep_q;

    // better-suffix refinement
    assign rf_sym     = cok_reg ? hist_q : '0;
    assign rf_match   = (rep_q == l_reg) && (rf_sym == a2_reg);
    assign rf_sym_src = (st_reg == ST_RF1) ? chead_q : cnext_q;
    assign slot_free  = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Next state
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:  if (s_valid) st_next = s_start_new ? ST_CLR : ST_START;
            ST_CLR:   st_next = pend_reg ? ST_START : ST_IDLE;
            ST_START: st_next = ST_LINK;
            ST_LINK:  st_next = kok ? ST_HEAD : ST_WEND;
            ST_HEAD:  st_next = head_miss ? ST_LINK : ST_EDGE;
            ST_EDGE: begin
                if (edge_hit)       st_next = ST_WEND;
                else if (edge_miss) st_next = ST_LINK;
            end
            ST_WEND: begin
                if (!pass2_reg)                         st_next = full_now ? ST_OUT : ST_START;
                else if (found_reg && tgt_reg != '0)    st_next = ST_CS0;
                else                                    st_next = ST_RF0;
            end
            ST_CS0:   st_next = ST_CS1;
            ST_CS1:   st_next = cs_short ? ST_RF0 : ST_CS2;
            ST_CS2:   st_next = cs_cont ? ST_CS2 : ST_RF0;
            ST_RF0:   st_next = ST_RF1;
            ST_RF1:   st_next = (chead_q == '0) ? ST_FIN0 : ST_RF2;
            ST_RF2: begin
                if (rf_match || cnext_q == '0) st_next = ST_FIN0;
            end
            ST_FIN0:  st_next = ST_FIN1;
            ST_FIN1:  st_next = ST_OUT;
            ST_OUT:   if (slot_free) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Store port control
    always_comb begin
        hist_we  = 1'b0; hist_wa  = '0; hist_wd  = '0; hist_ra  = '0;
        link_we  = 1'b0; link_wa  = '0; link_wd  = '0; link_ra  = '0;
        rep_we   = 1'b0; rep_wa   = '0; rep_wd   = '0; rep_ra   = '0;
        fedge_we = 1'b0; fedge_wa = '0; fedge_wd = '0; fedge_ra = '0;
        chead_we = 1'b0; chead_wa = '0; chead_wd = '0; chead_ra = '0;
        cnext_we = 1'b0; cnext_wa = '0; cnext_wd = '0; cnext_ra = '0;
        ctail_we = 1'b0; ctail_wa = '0; ctail_wd = '0; ctail_ra = '0;
        edge_we  = 1'b0; edge_wa  = ecnt_reg[EAW-1:0]; edge_ra = rd_ptr[EAW-1:0];
        enext_wd = head_val;
        case (st_reg)
            ST_CLR: begin
                // state zero: no edges, no children, repeat zero
                fedge_we = 1'b1;
                chead_we = 1'b1;
                rep_we   = 1'b1;
            end
            ST_START: begin
                link_ra  = pass2_reg ? n_reg : cnt_reg;
                fedge_ra = pass2_reg ? n_reg : cnt_reg;
            end
            ST_LINK: begin
                fedge_ra = link_q;
                // transition from the previous last state
                if (first_reg && pass2_reg) begin
                    edge_we  = 1'b1;
                    fedge_we = 1'b1;
                    fedge_wa = n_reg;
                    fedge_wd = ecnt_inc;
                end
            end
            ST_HEAD, ST_EDGE: begin
                link_ra = k_reg;
                if (miss && pass2_reg) begin
                    edge_we  = 1'b1;
                    fedge_we = 1'b1;
                    fedge_wa = k_reg;
                    fedge_wd = ecnt_inc;
                end
            end
            ST_WEND: begin
                // create the new state
                if (!pass2_reg && !full_now) begin
                    hist_we  = 1'b1; hist_wa  = n_reg + SW'(1); hist_wd = a_reg;
                    fedge_we = 1'b1; fedge_wa = n_reg + SW'(1);
                    chead_we = 1'b1; chead_wa = n_reg + SW'(1);
                    cnext_we = 1'b1; cnext_wa = n_reg + SW'(1);
                end
            end
            ST_CS0: begin
                link_ra = phi_reg;
                rep_ra  = phi_reg;
            end
            ST_CS1: begin
                link_ra = p2_reg;
                rep_ra  = p2_reg;
            end
            ST_CS2: begin
                link_ra = link_q;
                rep_ra  = link_q;
            end
            ST_RF0: begin
                hist_ra  = i_reg - l_reg;
                chead_ra = s_reg;
            end
            ST_RF1, ST_RF2: begin
                rep_ra   = rf_sym_src;
                cnext_ra = rf_sym_src;
                hist_ra  = rf_sym_src - l_reg;
            end
            ST_FIN0: begin
                chead_ra = s_reg;
                ctail_ra = s_reg;
            end
            ST_FIN1: begin
                link_we = 1'b1; link_wa = i_reg; link_wd = s_reg;
                rep_we  = 1'b1; rep_wa  = i_reg; rep_wd  = l_reg;
                // append to the child list of the link target
                if (chead_q == '0) begin
                    chead_we = 1'b1; chead_wa = s_reg; chead_wd = i_reg;
                end else begin
                    cnext_we = 1'b1; cnext_wa = ctail_q; cnext_wd = i_reg;
                end
                ctail_we = 1'b1; ctail_wa = s_reg; ctail_wd = i_reg;
            end
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer registers and datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_CLR;
            pend_reg    <= 1'b0;
            pass2_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            // a result leaving frees the slot unless the next one loads now
            if (m_valid_reg && m_ready && st_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (st_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        a_reg     <= YB'(s_symbol);
                        pend_reg  <= s_start_new;
                        pass2_reg <= 1'b0;
                    end
                end
                ST_CLR: begin
                    cnt_reg  <= '0;
                    ecnt_reg <= '0;
                    pend_reg <= 1'b0;
                end
                ST_START: begin
                    first_reg <= 1'b1;
                    need_reg  <= NW'(1);
                    if (!pass2_reg) begin
                        n_reg   <= cnt_reg;
                        src_reg <= cnt_reg;
                    end else begin
                        src_reg <= n_reg;
                        phi_reg <= n_reg;
                    end
                end
                ST_LINK: begin
                    k_reg     <= link_q;
                    first_reg <= 1'b0;
                    if (!kok) found_reg <= 1'b0;
                    if (first_reg && pass2_reg) ecnt_reg <= ecnt_inc;
                end
                ST_HEAD, ST_EDGE: begin
                    if (st_reg == ST_HEAD) head_reg <= fedge_q;
                    if (st_reg == ST_EDGE && edge_hit) begin
                        found_reg <= 1'b1;
                        tgt_reg   <= etgt_q;
                    end
                    if (miss) begin
                        src_reg  <= k_reg;
                        need_reg <= need_reg + NW'(1);
                        if (pass2_reg) begin
                            ecnt_reg <= ecnt_inc;
                            phi_reg  <= k_reg;
                        end
                    end
                end
                ST_WEND: begin
                    if (!pass2_reg) begin
                        res_full_reg <= full_now;
                        if (!full_now) begin
                            pass2_reg <= 1'b1;
                            i_reg     <= n_reg + SW'(1);
                            cnt_reg   <= n_reg + SW'(1);
                        end
                    end else if (found_reg) begin
                        s_reg  <= tgt_reg;
                        l_reg  <= SW'(1);
                        p2_reg <= tgt_reg - SW'(1);
                    end else begin
                        s_reg <= '0;
                        l_reg <= '0;
                    end
                end
                ST_CS1: begin
                    lp1_reg <= link_q;
                    rp1_reg <= rep_q;
                    if (cs_short) l_reg <= rep_q + SW'(1);
                end
                ST_CS2: begin
                    if (cs_cont) p2_reg <= link_q;
                    else         l_reg  <= rep_min + SW'(1);
                end
                ST_RF0: begin
                    a2ok_reg <= (l_reg < i_reg);
                end
                ST_RF1: begin
                    a2_reg  <= a2ok_reg ? hist_q : '0;
                    c_reg   <= chead_q;
                    cok_reg <= (chead_q > l_reg);
                end
                ST_RF2: begin
                    if (rf_match) begin
                        l_reg <= l_reg + SW'(1);
                        s_reg <= c_reg;
                    end else begin
                        c_reg   <= cnext_q;
                        cok_reg <= (cnext_q > l_reg);
                    end
                end
                ST_OUT: begin
                    if (slot_free) begin
                        m_valid_reg <= 1'b1;
                        m_full_reg  <= res_full_reg;
                        m_idx_reg   <= res_full_reg ? '0 : OUT_W'(i_reg);
                        m_link_reg  <= res_full_reg ? '0 : OUT_W'(s_reg);
                        m_rep_reg   <= res_full_reg ? '0 : OUT_W'(l_reg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign s_ready         = (st_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_state_index   = m_idx_reg;
    assign m_suffix_link   = m_link_reg;
    assign m_repeat_length = m_rep_reg;
    assign m_full_res      = m_full_reg;

endmodule

`default_nettype wire

FILE: sv/fo_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Standalone; instantiated by the top level for every oracle store.
`default_nettype none

module fo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and registered read (old data on collision)
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for factor_oracle_repeat_builder: directed and random symbol streams,
// checked against an in-bench oracle predictor. Depends on fo_pkg and the RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fo_pkg::*;

    localparam int NSTATES    = MAX_STATES_DEF;
    localparam int NEDGES     = MAX_EDGES_DEF;
    localparam int CYCLE_MAX  = 4000000;
    localparam int DRAIN_WAIT = 200;

    typedef struct packed {
        logic [OUT_W-1:0] idx;
        logic [OUT_W-1:0] lnk;
        logic [OUT_W-1:0] rep;
        logic             full;
    } oracle_res_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic [IN_SYM_W-1:0] s_symbol = '0;
    logic                s_start_new = 1'b0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [OUT_W-1:0]    m_state_index;
    logic [OUT_W-1:0]    m_suffix_link;
    logic [OUT_W-1:0]    m_repeat_length;
    logic                m_full_res;

    oracle_res_t pending_res[$];
    int          err_count = 0;
    int          cycle_count = 0;
    bit          no_idle = 1'b0;

    // Predictor copy of the oracle
    logic [7:0] hist[NSTATES];
    int         link_st[NSTATES];
    int         rep_st[NSTATES];
    int         edge_head[NSTATES];
    int         e_sym[NEDGES];
    int         e_tgt[NEDGES];
    int         e_nxt[NEDGES];
    int         ch_head[NSTATES];
    int         ch_next[NSTATES];
    int         ch_tail[NSTATES];
    int         n_edges;
    int         n_states;

    factor_oracle_repeat_builder dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_symbol       (s_symbol),
        .s_start_new    (s_start_new),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_state_index  (m_state_index),
        .m_suffix_link  (m_suffix_link),
        .m_repeat_length(m_repeat_length),
        .m_full_res     (m_full_res)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_MAX) begin
            $display("** factor_oracle_repeat_builder: FAILED **");
            $finish;
        end
    end

    function automatic void oracle_clear();
        for (int j = 0; j < NSTATES; j++) begin
            hist[j] = '0;
            link_st[j] = 0;
            rep_st[j] = 0;
            edge_head[j] = 0;
            ch_head[j] = 0;
            ch_next[j] = 0;
            ch_tail[j] = 0;
        end
        link_st[0] = -1;
        n_edges = 0;
        n_states = 0;
    endfunction

    function automatic int history_at(int pos);
        if (pos < 1 || pos > n_states) return 0;
        return hist[pos];
    endfunction

    // Target+1 of the transition from st on sym, 0 when absent
    function automatic int transition_of(int st, int sym);
        int e;
        e = edge_head[st];
        while (e != 0) begin
            if (e_sym[e-1] == sym) return e_tgt[e-1] + 1;
            e = e_nxt[e-1];
        end
        return 0;
    endfunction

    function automatic void add_transition(int st, int sym, int tgt);
        if (n_edges >= NEDGES) return;
        e_sym[n_edges] = sym;
        e_tgt[n_edges] = tgt;
        e_nxt[n_edges] = edge_head[st];
        edge_head[st] = n_edges + 1;
        n_edges++;
    endfunction

    function automatic int shared_suffix_len(int p1, int p2);
        int steps;
        steps = 0;
        if (p2 == link_st[p1]) return rep_st[p1];
        while (link_st[p1] != link_st[p2] && link_st[p2] >= 0 && steps < NSTATES) begin
            p2 = link_st[p2];
            steps++;
        end
        return (rep_st[p1] <= rep_st[p2]) ? rep_st[p1] : rep_st[p2];
    endfunction

    // Extend the oracle by one symbol and return the new state's summary, or a full result when the stores are full
    function automatic oracle_res_t oracle_extend(logic [7:0] sym_in, logic clr);
        oracle_res_t r;
        int sym, n, ni, need, k, phi, s, l, a2, c, steps;
        sym = sym_in;
        if (clr) oracle_clear();
        n = n_states;
        need = 1;
        k = link_st[n];
        while (k >= 0 && transition_of(k, sym) == 0) begin
            need++;
            k = link_st[k];
        end
        if (n + 1 >= NSTATES || n_edges + need > NEDGES) begin
            r = '0;
            r.full = 1'b1;
            return r;
        end
        ni = n + 1;
        hist[ni] = sym_in;
        n_states = ni;
        edge_head[ni] = 0;
        ch_head[ni] = 0;
        ch_next[ni] = 0;
        add_transition(n, sym, ni);
        phi = n;
        k = link_st[n];
        while (k >= 0 && transition_of(k, sym) == 0) begin
            add_transition(k, sym, ni);
            phi = k;
            k = link_st[k];
        end
        if (k < 0) begin
            s = 0;
            l = 0;
        end else begin
            s = transition_of(k, sym) - 1;
            l = ((s >= 1) ? shared_suffix_len(phi, s - 1) : 0) + 1;
        end
        // Better-suffix refinement over children of the link target
        a2 = history_at(ni - l);
        c = ch_head[s];
        steps = 0;
        while (c != 0 && c < NSTATES && steps < NSTATES) begin
            if (rep_st[c] == l && history_at(c - l) == a2) begin
                l = l + 1;
                s = c;
                break;
            end
            c = ch_next[c];
            steps++;
        end
        link_st[ni] = s;
        rep_st[ni] = l;
        if (ch_head[s] == 0) ch_head[s] = ni;
        else ch_next[ch_tail[s]] = ni;
        ch_tail[s] = ni;
        r.idx = ni[OUT_W-1:0];
        r.lnk = s[OUT_W-1:0];
        r.rep = l[OUT_W-1:0];
        r.full = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        err_count++;
    endtask

    // One input transfer; valid stays high for a back-to-back follower
    task automatic send_symbol(logic [7:0] sym, logic clr);
        int gap;
        oracle_res_t exp_res;
        if (!no_idle && $urandom_range(99) < 6) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_symbol    <= sym;
        s_start_new <= clr;
        do @(posedge aclk); while (!s_ready);
        exp_res = oracle_extend(sym, clr);
        pending_res.insert(pending_res.size(), exp_res);
    endtask

    // Output backpressure
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 6);
    end

    // Result checker
    always @(posedge aclk) begin
        oracle_res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_res.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = pending_res.pop_front();
                if (m_state_index !== want.idx)
                    report_mismatch($sformatf("state_index %0d, want %0d",
                                              m_state_index, want.idx));
                if (m_suffix_link !== want.lnk)
                    report_mismatch($sformatf("suffix_link %0d, want %0d",
                                              m_suffix_link, want.lnk));
                if (m_repeat_length !== want.rep)
                    report_mismatch($sformatf("repeat_length %0d, want %0d",
                                              m_repeat_length, want.rep));
                if (m_full_res !== want.full)
                    report_mismatch($sformatf("full_res %0b, want %0b",
                                              m_full_res, want.full));
            end
        end
    end

    // Symbol extremes and oracle restarts
    task automatic test_extremes();
        send_symbol(8'h00, 1'b1);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'h00, 1'b0);
        send_symbol(8'hFF, 1'b0);
        send_symbol(8'hAA, 1'b1);
        send_symbol(8'h55, 1'b0);
        send_symbol(8'hAA, 1'b1);
    endtask

    // Repeats drive the common-suffix walk and the refinement scan
    task automatic test_repeats();
        logic [7:0] word[] = '{8'd1, 8'd2, 8'd1, 8'd2, 8'd1, 8'd1, 8'd2, 8'd3, 8'd1, 8'd2,
                               8'd3, 8'd3, 8'd3, 8'd3, 8'd1, 8'd2};
        foreach (word[j]) send_symbol(word[j], j == 0);
    endtask

    // Fill the state store, then keep sending to check the full results, then restart
    task automatic test_store_full();
        no_idle = 1'b1;
        for (int j = 0; j < NSTATES + 6; j++) begin
            if (j == 200) no_idle = 1'b0;
            send_symbol(8'($urandom_range(0, 3)), j == 0);
        end
        send_symbol(8'h07, 1'b1);
    endtask

    // Random words; mostly small alphabets so repeats are frequent
    task automatic test_random_words();
        int len, alpha, sent;
        sent = 0;
        while (sent < 150) begin
            len = $urandom_range(1, 40);
            case ($urandom_range(3))
                0: alpha = 2;
                1: alpha = 4;
                2: alpha = 16;
                default: alpha = 256;
            endcase
            for (int j = 0; j < len; j++) begin
                send_symbol(8'($urandom_range(0, alpha - 1)),
                            (j == 0) || ($urandom_range(99) == 0));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        oracle_clear();
        test_extremes();
        test_repeats();
        test_store_full();
        test_random_words();
        s_valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0) begin
            $display("** factor_oracle_repeat_builder: PASSED **");
        end else begin
            $display("** factor_oracle_repeat_builder: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
